// ----- hdl/hsilp_pkg.sv -----
package hsilp_pkg;

   localparam int KEY_SHIFT = 24;
   localparam int KEY_W = 32;
   localparam int PICK_W = 8;
   localparam int ORDER_W = 24;
   localparam int SIZE_W = 13;
   localparam int SLOT_W = 13;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
   localparam int TABLE_DEPTH_DEFAULT = 4096;

   typedef struct packed {
      logic [PICK_W-1:0]  pickline;
      logic [ORDER_W-1:0] order_number;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_number;
      logic              inserted;
   } rsp_type;

endpackage

// ----- hdl/hash_slot_insert_linear_probe_top.sv -----
// sequence: 32 remainder steps find the home slot, then each slot probed takes a read and a
//   check state through the registered table read; a zero size goes straight to the result
// throughput: one item at a time, busy stays high until the result is issued
// reset: synchronous, clears control, table size returns to 4096, then a clearing pass
//   writes zero to every slot while busy is high
// the receiver cannot stall: rsp_valid is a one-cycle strobe
module hash_slot_insert_linear_probe_top #(
   parameter int TABLE_DEPTH = hsilp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hsilp_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output hsilp_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hsilp_pkg::SIZE_W-1:0]        csr_data
);

   // index width and a width that can hold the depth itself
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > hsilp_pkg::SIZE_W) ? CNT_W : hsilp_pkg::SIZE_W;
   localparam int STEP_W = $clog2(hsilp_pkg::KEY_W);
   localparam int WORD_W = hsilp_pkg::PICK_W + hsilp_pkg::ORDER_W;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_READ  = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [hsilp_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [hsilp_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            probe_ff, probe_in;
   hsilp_pkg::req_type          item_ff, item_in;
   hsilp_pkg::rsp_type          rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // table: pickline in the upper byte, zero pickline means empty
   logic [WORD_W-1:0]           mem [TABLE_DEPTH];
   logic [WORD_W-1:0]           rd_data_ff;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [WORD_W-1:0]           wr_data;

   logic [CMP_W-1:0]            size_ext;
   logic [CMP_W-1:0]            depth_ext;
   logic [CNT_W-1:0]            n_used;
   logic [CNT_W:0]              rem_sh;
   logic                        rem_ge;
   logic [CNT_W-1:0]            idx_inc;
   logic [CNT_W-1:0]            probe_inc;
   logic [IDX_W:0]              slot_sum;
   logic                        slot_free;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // slots in use, saturated at the table depth
   always_comb begin
      size_ext  = CMP_W'(size_ff);
      depth_ext = CMP_W'(TABLE_DEPTH);
      if (size_ext > depth_ext) begin
         n_used = CNT_W'(depth_ext);
      end else begin
         n_used = CNT_W'(size_ext);
      end
   end

   // restoring remainder step, one key bit per cycle
   assign rem_sh = {rem_ff, key_ff[hsilp_pkg::KEY_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, n_ff});

   assign idx_inc   = CNT_W'({1'b0, idx_ff}) + CNT_W'(1);
   assign probe_inc = probe_ff + CNT_W'(1);
   assign slot_sum  = {1'b0, idx_ff} + (IDX_W + 1)'(1);
   assign slot_free = (rd_data_ff[WORD_W-1 -: hsilp_pkg::PICK_W] == '0);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      n_in         = n_ff;
      key_in       = key_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {hsilp_pkg::PICK_W'(item_ff.pickline), item_ff.order_number};

      if (csr_valid && csr_ready) begin
         size_in = csr_data;
      end

      case (state_ff)
         // empty every slot after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            idx_in  = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               item_in  = req_data;
               n_in     = n_used;
               key_in   = {req_data.pickline, req_data.order_number};
               rem_in   = '0;
               step_in  = '0;
               probe_in = '0;
               if (n_used == '0) begin
                  // nothing in use, answer empty-handed
                  rsp_in   = '{slot_number: '0, inserted: 1'b0};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         // home slot = key mod n
         ST_DIV: begin
            if (rem_ge) begin
               rem_in = CNT_W'(rem_sh - {1'b0, n_ff});
            end else begin
               rem_in = CNT_W'(rem_sh);
            end
            key_in  = {key_ff[hsilp_pkg::KEY_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(hsilp_pkg::KEY_W - 1)) begin
               idx_in   = IDX_W'(rem_in);
               state_in = ST_READ;
            end
         end
         // address goes out, data comes back registered
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slot_free) begin
               wr_en    = 1'b1;
               rsp_in   = '{slot_number: hsilp_pkg::SLOT_W'(slot_sum), inserted: 1'b1};
               state_in = ST_DONE;
            end else if (probe_inc == n_ff) begin
               // every slot in use was taken
               rsp_in   = '{slot_number: '0, inserted: 1'b0};
               state_in = ST_DONE;
            end else begin
               probe_in = probe_inc;
               if (idx_inc == n_ff) begin
                  idx_in = '0;
               end else begin
                  idx_in = IDX_W'(idx_inc);
               end
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= hsilp_pkg::SIZE_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      key_ff   <= key_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      probe_ff <= probe_in;
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
   end

   // table memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff];
   end

endmodule

// ----- hdl/hsilp_checker.sv -----
module hsilp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input hsilp_pkg::rsp_type            rsp_data
);

   // an accepted item holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted item");

   // no result in the cycle after an accept
   a_accept_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result too early after accept");

   // one result per item, a single-cycle strobe
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // result shows as the block goes idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result without a finished item");

   // a miss carries no slot number
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.inserted) |-> (rsp_data.slot_number == '0))
      else $error("slot number on a miss");

endmodule

bind hash_slot_insert_linear_probe_top hsilp_checker u_hsilp_checker (.*);

// ----- bench/hash_slot_insert_linear_probe_top_tb.sv -----
`timescale 1ns / 100ps

module hash_slot_insert_linear_probe_top_tb;

   localparam int TB_DEPTH = hsilp_pkg::TABLE_DEPTH_DEFAULT;
   localparam int MAX_SHOWN = 10;
   // cycles left after the last result before a register write or the verdict
   localparam int SETTLE_CYCLES = 40;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   hsilp_pkg::req_type           req_data;
   logic                         rsp_valid;
   hsilp_pkg::rsp_type           rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [hsilp_pkg::SIZE_W-1:0] csr_data;

   // shadow copy of the table: only the pickline decides whether a slot is free
   logic [hsilp_pkg::PICK_W-1:0] slot_pick_model [TB_DEPTH];
   logic [hsilp_pkg::SIZE_W-1:0] size_model;

   // items waiting for the driver, and slot answers waiting for the block
   hsilp_pkg::req_type pending_inserts [$];
   hsilp_pkg::rsp_type expected_slots [$];
   hsilp_pkg::rsp_type oldest_slot;

   int     mismatch_count;
   int     placed_count;
   int     refused_count;
   int     insert_count;
   int     setting_count;
   int     idle_pct;
   bit     item_taken;
   longint cycle_count;
   longint cycle_limit;

   hash_slot_insert_linear_probe_top #(
      .TABLE_DEPTH(TB_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // slots in use: a size above the table depth saturates to the depth
   function automatic logic [31:0] slots_in_use();
      return (size_model > TB_DEPTH) ? 32'(TB_DEPTH) : 32'(size_model);
   endfunction

   // hash to the home slot, walk to the last slot in use, wrap to slot 0,
   // stop just before home; first empty slot takes the item
   function automatic hsilp_pkg::rsp_type predict_insert(hsilp_pkg::req_type item);
      logic [31:0]        used;
      logic [31:0]        home;
      logic [31:0]        probe;
      logic [31:0]        slot;
      bit                 hit;
      hsilp_pkg::rsp_type answer;
      answer = '0;
      hit = 1'b0;
      slot = '0;
      used = slots_in_use();
      // zero size: nothing is in use, the table is left alone
      if (used != 0) begin
         // pickline above the order number is the 32-bit key
         home = {item.pickline, item.order_number} % used;
         for (probe = home; probe < used && !hit; probe++) begin
            if (slot_pick_model[probe] == '0) begin
               hit = 1'b1;
               slot = probe;
            end
         end
         for (probe = 0; probe < home && !hit; probe++) begin
            if (slot_pick_model[probe] == '0) begin
               hit = 1'b1;
               slot = probe;
            end
         end
         // a zero pickline is written too, so its slot still looks empty
         if (hit) begin
            slot_pick_model[slot] = item.pickline;
            answer.slot_number = hsilp_pkg::SLOT_W'(slot + 1);
            answer.inserted = 1'b1;
         end
      end
      return answer;
   endfunction

   // the slowest correct item walks every slot in use, plus a long sender gap
   task automatic queue_insert(input logic [hsilp_pkg::PICK_W-1:0] pickline,
                               input logic [hsilp_pkg::ORDER_W-1:0] order_number);
      hsilp_pkg::req_type item;
      item.pickline = pickline;
      item.order_number = order_number;
      pending_inserts.push_back(item);
      cycle_limit += 4 * (2 * longint'(slots_in_use()) + 150);
   endtask

   // sender stays quiet until the block has answered everything queued
   task automatic wait_drained();
      while (pending_inserts.size() != 0 || expected_slots.size() != 0 || start)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [hsilp_pkg::SIZE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      size_model = value;
      setting_count++;
      cycle_limit += 1000;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [hsilp_pkg::SIZE_W-1:0] size, input int count,
                                   input int pct);
      logic [hsilp_pkg::PICK_W-1:0]  pickline;
      logic [hsilp_pkg::ORDER_W-1:0] order_number;
      wait_drained();
      write_table_size(size);
      idle_pct = pct;
      repeat (count) begin
         // mostly real picklines, now and then a zero one
         pickline = ($urandom_range(31) == 0) ? 8'h00 :
                    hsilp_pkg::PICK_W'($urandom_range(255, 1));
         case ($urandom_range(15))
            0:       order_number = '0;
            1:       order_number = '1;
            default: order_number = hsilp_pkg::ORDER_W'($urandom);
         endcase
         queue_insert(pickline, order_number);
      end
   endtask

   // free-running cycle count for the watchdog
   always @(posedge clock) begin
      cycle_count++;
   end

   // watchdog: the limit grows as items are queued
   initial begin
      while (cycle_count <= cycle_limit) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // results are checked before a new item is taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_slots.size() == 0) begin
               if (mismatch_count < MAX_SHOWN)
                  $display("cycle %0d: result slot %0d inserted %0b with none pending",
                           cycle_count, rsp_data.slot_number, rsp_data.inserted);
               mismatch_count++;
            end else begin
               oldest_slot = expected_slots.pop_front();
               if (oldest_slot.inserted)
                  placed_count++;
               else
                  refused_count++;
               if (rsp_data.slot_number !== oldest_slot.slot_number ||
                   rsp_data.inserted !== oldest_slot.inserted) begin
                  if (mismatch_count < MAX_SHOWN)
                     $display("cycle %0d: slot_number exp %0d got %0d, inserted exp %0b got %0b",
                              cycle_count, oldest_slot.slot_number, rsp_data.slot_number,
                              oldest_slot.inserted, rsp_data.inserted);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_slots.push_back(predict_insert(req_data));
            void'(pending_inserts.pop_front());
            insert_count++;
            item_taken = 1'b1;
         end
      end
   end

   // driver: hold the item until taken, then offer the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         item_taken = 1'b0;
         if (pending_inserts.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= pending_inserts[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      size_model = hsilp_pkg::SIZE_RESET;
      foreach (slot_pick_model[i]) slot_pick_model[i] = '0;
      mismatch_count = 0;
      placed_count = 0;
      refused_count = 0;
      insert_count = 0;
      setting_count = 0;
      idle_pct = 0;
      item_taken = 1'b0;
      cycle_count = 0;
      // reset plus the clearing pass over every slot
      cycle_limit = 4 * (TB_DEPTH + 1000);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // size out of reset, no write yet
      // all-ones key lands on the last slot, the same key again wraps to slot 0
      queue_insert(8'hFF, 24'hFFFFFF);
      queue_insert(8'hFF, 24'hFFFFFF);
      // home is slot 0, already taken, so it steps on
      queue_insert(8'h01, 24'h000000);
      // zero pickline twice: the slot stays empty and is handed out again
      queue_insert(8'h00, 24'h000005);
      queue_insert(8'h00, 24'h000005);
      queue_insert(8'h80, 24'h800000);

      // zero size turns everything away
      wait_drained();
      write_table_size('0);
      queue_insert(8'h01, 24'h000000);
      queue_insert(8'hFF, 24'hFFFFFF);

      // largest register value saturates to the table depth
      wait_drained();
      write_table_size('1);
      queue_insert(8'hFF, 24'hFFFFFE);

      // one slot, already full
      wait_drained();
      write_table_size(13'd1);
      queue_insert(8'h07, 24'h00007B);

      // a few free slots, then a full table
      wait_drained();
      write_table_size(13'd5);
      queue_insert(8'h01, 24'h000003);
      queue_insert(8'h02, 24'h000003);
      queue_insert(8'h03, 24'h000003);

      // growing tables so earlier entries crowd the low slots and force long walks
      run_random_phase(13'd16, 120, 0);
      run_random_phase(13'd100, 150, 64);
      run_random_phase(13'd333, 200, 0);
      run_random_phase(13'd1000, 250, 29);
      run_random_phase(13'd4096, 250, 64);
      run_random_phase('1, 200, 0);
      // tiny table long since full
      run_random_phase(13'd2, 80, 29);

      wait_drained();
      $display("%0d inserts checked across %0d table size settings", insert_count,
               setting_count);
      $display("%0d placed in a slot, %0d turned away by a full or empty-size table",
               placed_count, refused_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
